### hdl/olad_pkg.sv
// Shared constants and codes for the ordered list append/delete unit.
package olad_pkg;

    localparam int DEPTH      = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);

    localparam int FUNC_W    = 2;
    localparam int INVAL_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int ELEM_W    = 32;
    localparam int REMOVED_W = 6;

    typedef logic [FUNC_W-1:0]     t_func;
    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [CNT_BITS-1:0]   t_cnt;

    localparam t_func FUNC_APPEND   = 2'd0;
    localparam t_func FUNC_DELETE   = 2'd1;
    localparam t_func FUNC_TRAVERSE = 2'd2;

    localparam t_status ST_APPENDED  = 3'd0;
    localparam t_status ST_DROPPED   = 3'd1;
    localparam t_status ST_DELETED   = 3'd2;
    localparam t_status ST_NOT_FOUND = 3'd3;
    localparam t_status ST_ELEMENT   = 3'd4;
    localparam t_status ST_EMPTY     = 3'd5;

endpackage

### hdl/olad_if.sv
// Handshake interfaces for the command words and the result words.
interface olad_cmd_if;
    logic                                valid;
    logic                                ready;
    olad_pkg::t_func                     func;
    logic signed [olad_pkg::INVAL_W-1:0] value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

interface olad_res_if;
    logic                                  valid;
    logic                                  ready;
    olad_pkg::t_status                     status;
    logic signed [olad_pkg::ELEM_W-1:0]    element;
    logic        [olad_pkg::REMOVED_W-1:0] removed;
    logic                                  last;

    modport source (output valid, status, element, removed, last, input ready);
    modport sink   (input valid, status, element, removed, last, output ready);
endinterface

### hdl/ordered_list_append_delete_unit.sv
// Ordered list with append at the tail, delete of all equal entries and traversal.
// Append, and traversal of an empty list: result word valid the cycle after the command.
// Delete: walk at one entry per cycle, then the result word when the output is free.
// Traverse: per entry a memory read, then the result register, which waits on a stall.
// A reserved code is dropped without a result; a new command word is taken only when idle
// with the result register free. Reset empties the list; the storage is not cleared.
module ordered_list_append_delete_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    olad_cmd_if.sink  i_cmd,
    olad_res_if.source o_res
);
    import olad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEL_WALK,
        S_DEL_DONE,
        S_TR_RD,
        S_TR_EMIT
    } t_state;

    t_state  r_state, n_state;
    t_cnt    r_count, n_count;
    t_cnt    r_rd_idx, n_rd_idx;
    t_cnt    r_wr_idx, n_wr_idx;
    logic    r_rd_vld, n_rd_vld;
    t_value  r_value, n_value;

    logic                  r_out_vld, n_out_vld;
    t_status               r_status, n_status;
    logic [ELEM_W-1:0]     r_element, n_element;
    logic [REMOVED_W-1:0]  r_removed, n_removed;
    logic                  r_last, n_last;

    // List storage, one write and one registered read port.
    t_value                mem [DEPTH];
    t_value                r_rd_data;
    logic                  mem_we, mem_re;
    logic [IDX_BITS-1:0]   mem_waddr, mem_raddr;
    t_value                mem_wdata;

    logic out_free, cmd_take, issue, tr_final;

    assign out_free = !r_out_vld || o_res.ready;
    assign cmd_take = i_cmd.valid && i_cmd.ready;
    assign issue    = (r_rd_idx < r_count);
    assign tr_final = (CNT_BITS'(r_rd_idx + 1'b1) == r_count);

    assign i_cmd.ready    = (r_state == S_IDLE) && out_free;
    assign o_res.valid    = r_out_vld;
    assign o_res.status   = r_status;
    assign o_res.element  = r_element;
    assign o_res.removed  = r_removed;
    assign o_res.last     = r_last;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_wr_idx  = r_wr_idx;
        n_rd_vld  = r_rd_vld;
        n_value   = r_value;
        n_out_vld = r_out_vld && !o_res.ready;
        n_status  = r_status;
        n_element = r_element;
        n_removed = r_removed;
        n_last    = r_last;
        mem_we    = 1'b0;
        mem_waddr = r_wr_idx[IDX_BITS-1:0];
        mem_wdata = r_rd_data;
        mem_re    = 1'b0;
        mem_raddr = r_rd_idx[IDX_BITS-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (cmd_take) begin
                    case (i_cmd.func)
                        FUNC_APPEND: begin
                            n_out_vld = 1'b1;
                            n_element = '0;
                            n_removed = '0;
                            n_last    = 1'b1;
                            if (r_count >= CNT_BITS'(DEPTH)) begin
                                n_status = ST_DROPPED;
                            end else begin
                                n_status  = ST_APPENDED;
                                mem_we    = 1'b1;
                                mem_waddr = r_count[IDX_BITS-1:0];
                                mem_wdata = i_cmd.value[VALUE_BITS-1:0];
                                n_count   = CNT_BITS'(r_count + 1'b1);
                            end
                        end
                        FUNC_DELETE: begin
                            n_value  = i_cmd.value[VALUE_BITS-1:0];
                            n_rd_idx = '0;
                            n_wr_idx = '0;
                            n_rd_vld = 1'b0;
                            n_state  = S_DEL_WALK;
                        end
                        FUNC_TRAVERSE: begin
                            if (r_count == '0) begin
                                n_out_vld = 1'b1;
                                n_status  = ST_EMPTY;
                                n_element = '0;
                                n_removed = '0;
                                n_last    = 1'b1;
                            end else begin
                                n_rd_idx = '0;
                                n_state  = S_TR_RD;
                            end
                        end
                        default: ;  // reserved code: word is dropped without a result
                    endcase
                end
            end
            S_DEL_WALK: begin
                // Reads run one entry ahead of the compare; survivors are packed down
                // to the write index, which never overtakes the read index.
                mem_re   = issue;
                n_rd_vld = issue;
                if (issue) begin
                    n_rd_idx = CNT_BITS'(r_rd_idx + 1'b1);
                end
                if (r_rd_vld && (r_rd_data != r_value)) begin
                    mem_we   = 1'b1;
                    n_wr_idx = CNT_BITS'(r_wr_idx + 1'b1);
                end
                if (!issue && !r_rd_vld) begin
                    n_state = S_DEL_DONE;
                end
            end
            S_DEL_DONE: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_status  = (r_wr_idx == r_count) ? ST_NOT_FOUND : ST_DELETED;
                    n_element = '0;
                    n_removed = REMOVED_W'(r_count - r_wr_idx);
                    n_last    = 1'b1;
                    n_count   = r_wr_idx;
                    n_state   = S_IDLE;
                end
            end
            S_TR_RD: begin
                mem_re  = 1'b1;
                n_state = S_TR_EMIT;
            end
            S_TR_EMIT: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_status  = ST_ELEMENT;
                    n_element = ELEM_W'($signed(r_rd_data));
                    n_removed = '0;
                    n_last    = tr_final;
                    n_rd_idx  = CNT_BITS'(r_rd_idx + 1'b1);
                    n_state   = tr_final ? S_IDLE : S_TR_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_wr_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_idx  <= n_rd_idx;
            r_wr_idx  <= n_wr_idx;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
        r_value   <= n_value;
        r_status  <= n_status;
        r_element <= n_element;
        r_removed <= n_removed;
        r_last    <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("list count exceeds depth");

    a_pack_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL_WALK) |-> (r_wr_idx <= r_rd_idx))
        else $error("delete write index overtook read index");

    a_append_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_take && (i_cmd.func == FUNC_APPEND) && (r_count < CNT_BITS'(DEPTH)))
        |=> (r_count == CNT_BITS'($past(r_count) + 1'b1)))
        else $error("append did not grow the list");

    a_busy_mid_walk : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_status == ST_ELEMENT) && !r_last) |-> (r_state != S_IDLE))
        else $error("sequencer idle while traversal unfinished");

endmodule
